// ===== hdl/tksrt_pkg.sv =====
// Package for the slow-request table: sizes, request/result beat types,
// status and operation codes, sequencer states and the cell control struct.
// No dependencies.
`default_nettype none

package tksrt_pkg;

    localparam int SLOTS  = 16;
    localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int DUMP_N = (SLOTS < 16) ? SLOTS : 16;

    localparam logic [31:0] THRESHOLD_RESET = 32'd10000;

    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_DUMP  = 2'd2;

    typedef enum logic [2:0] {
        STS_BELOW      = 3'd0,
        STS_NOT_SLOW   = 3'd1,
        STS_NOT_SLOWER = 3'd2,
        STS_UPDATED    = 3'd3,
        STS_INSERTED   = 3'd4,
        STS_REPLACED   = 3'd5,
        STS_ENTRY      = 3'd6
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_MIN,
        S_EMIT,
        S_DUMP
    } t_fsm;

    typedef struct packed {
        logic [1:0]  operation;
        logic [63:0] key_hash;
        logic [31:0] latency;
        logic [39:0] timestamp;
    } t_req;

    typedef struct packed {
        t_status     status;
        logic [3:0]  slot;
        logic        entry_valid;
        logic [63:0] entry_key;
        logic [31:0] entry_latency;
        logic [39:0] entry_time;
        logic        last;
    } t_rsp;

    typedef struct packed {
        logic [63:0] key;
        logic [31:0] latency;
        logic [39:0] time_s;
    } t_entry;

    typedef struct packed {
        logic shift;
        logic wr;
    } t_cell_ctl;

endpackage

`default_nettype wire

// ===== hdl/tksrt_cell.sv =====
// One table cell: holds an entry, matches the broadcast key, flags the minimum
// and passes a running minimum and its entry to the neighbouring cell.
// Depends on tksrt_pkg.
`default_nettype none

module tksrt_cell (
    input  wire logic               i_clk,
    input  wire tksrt_pkg::t_cell_ctl i_ctl,
    input  wire tksrt_pkg::t_entry  i_wr_entry,
    input  wire tksrt_pkg::t_entry  i_next,
    input  wire logic               i_in_use,
    input  wire logic [63:0]        i_key,
    input  wire logic [31:0]        i_lowest,
    input  wire logic [31:0]        i_min,
    output logic [31:0]             o_min,
    output tksrt_pkg::t_entry       o_entry,
    output logic                    o_match,
    output logic                    o_at_min
);
    import tksrt_pkg::*;

    t_entry      r_entry;
    logic [31:0] r_min;
    logic [31:0] n_min;

    always_comb begin
        n_min = (i_in_use && (r_entry.latency < i_min)) ? r_entry.latency : i_min;
    end

    // write from the sequencer wins; shift rotates the row during a dump
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_entry <= i_wr_entry;
        end else if (i_ctl.shift) begin
            r_entry <= i_next;
        end
        r_min <= n_min;
    end

    assign o_min    = r_min;
    assign o_entry  = r_entry;
    assign o_match  = i_in_use && (r_entry.key == i_key);
    assign o_at_min = i_in_use && (r_entry.latency == i_lowest);

endmodule

`default_nettype wire

// ===== hdl/top_k_slowest_request_table.sv =====
// Slow-request table: a row of SLOTS cells plus the sequencer that drives it.
// Add: on a write the minimum ripples one cell per cycle through S_MIN; a
// dropped add goes from S_LOOK to S_EMIT. Dump: one beat per cycle unless the
// output stalls, one entry-less beat when empty. Clear: no beat. One item at a
// time; the output register frees the consumer side. Synchronous active-low
// reset empties the table, sets the threshold to 10000; entry storage is not cleared.
`default_nettype none

module top_k_slowest_request_table (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_cfg_we,
    input  wire logic [31:0]    i_cfg_wdata,
    input  wire logic           i_in_valid,
    output logic                o_in_stall,
    input  wire tksrt_pkg::t_req i_in,
    output logic                o_out_valid,
    input  wire logic           i_out_stall,
    output tksrt_pkg::t_rsp     o_out
);
    import tksrt_pkg::*;

    t_fsm              r_state, n_state;
    t_req              r_req;
    logic [31:0]       r_threshold;
    logic [CNT_W-1:0]  r_used, n_used;
    logic [31:0]       r_lowest, n_lowest;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    t_rsp              r_pend, n_pend;
    logic              r_out_valid, n_out_valid;
    t_rsp              r_out, n_out;

    t_cell_ctl         w_ctl      [SLOTS];
    t_entry            w_entry    [SLOTS];
    logic [31:0]       w_min_out  [SLOTS];
    logic [SLOTS-1:0]  w_match;
    logic [SLOTS-1:0]  w_at_min;
    logic [SLOTS-1:0]  w_in_use;

    logic              w_accept;
    logic              w_full;
    logic              w_out_free;
    logic              w_any_match;
    logic [IDX_W-1:0]  w_match_idx;
    logic [IDX_W-1:0]  w_min_idx;
    logic [CNT_W-1:0]  w_dump_n;
    logic              w_wr_en;
    logic [IDX_W-1:0]  w_wr_sel;
    logic              w_shift;
    logic              w_emit;

    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);
    assign w_full     = (r_used == CNT_W'(SLOTS));
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_dump_n   = (r_used > CNT_W'(DUMP_N)) ? CNT_W'(DUMP_N) : r_used;

    genvar g;
    generate
        for (g = 0; g < SLOTS; g++) begin : g_cell
            logic [31:0] w_min_in;
            if (g == 0) begin : g_head
                assign w_min_in = '1;
            end else begin : g_body
                assign w_min_in = w_min_out[g-1];
            end

            assign w_in_use[g] = (CNT_W'(g) < r_used);

            tksrt_cell u_cell (
                .i_clk      (i_clk),
                .i_ctl      (w_ctl[g]),
                .i_wr_entry ('{key: r_req.key_hash, latency: r_req.latency,
                               time_s: r_req.timestamp}),
                .i_next     (w_entry[(g + 1) % SLOTS]),
                .i_in_use   (w_in_use[g]),
                .i_key      (r_req.key_hash),
                .i_lowest   (r_lowest),
                .i_min      (w_min_in),
                .o_min      (w_min_out[g]),
                .o_entry    (w_entry[g]),
                .o_match    (w_match[g]),
                .o_at_min   (w_at_min[g])
            );
        end
    endgenerate

    // first matching key and first entry at the minimum
    always_comb begin
        w_match_idx = '0;
        w_min_idx   = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (w_match[i]) begin
                w_match_idx = IDX_W'(i);
            end
            if (w_at_min[i]) begin
                w_min_idx = IDX_W'(i);
            end
        end
    end
    assign w_any_match = |w_match;

    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            w_ctl[i].shift = w_shift;
            w_ctl[i].wr    = w_wr_en && (w_wr_sel == IDX_W'(i));
        end
    end

    always_comb begin
        n_state     = r_state;
        n_used      = r_used;
        n_lowest    = r_lowest;
        n_cnt       = r_cnt;
        n_pend      = r_pend;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        w_wr_en     = 1'b0;
        w_wr_sel    = w_match_idx;
        w_shift     = 1'b0;
        w_emit      = (r_cnt < w_dump_n);

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                n_pend      = '0;
                n_pend.last = 1'b1;
                n_state     = S_EMIT;
                n_cnt       = '0;
                case (r_req.operation)
                    OP_ADD: begin
                        if (r_req.latency < r_threshold) begin
                            n_pend.status = STS_BELOW;
                        end else if (w_full && (r_req.latency <= r_lowest)) begin
                            n_pend.status = STS_NOT_SLOW;
                        end else if (w_any_match) begin
                            n_pend.slot = 4'(w_match_idx);
                            if (r_req.latency <= w_entry[w_match_idx].latency) begin
                                n_pend.status = STS_NOT_SLOWER;
                            end else begin
                                n_pend.status = STS_UPDATED;
                                w_wr_en       = 1'b1;
                                w_wr_sel      = w_match_idx;
                                n_state       = S_MIN;
                            end
                        end else if (!w_full) begin
                            n_pend.status = STS_INSERTED;
                            n_pend.slot   = 4'(r_used);
                            w_wr_en       = 1'b1;
                            w_wr_sel      = r_used[IDX_W-1:0];
                            n_used        = r_used + 1'b1;
                            n_state       = S_MIN;
                        end else begin
                            n_pend.status = STS_REPLACED;
                            n_pend.slot   = 4'(w_min_idx);
                            w_wr_en       = 1'b1;
                            w_wr_sel      = w_min_idx;
                            n_state       = S_MIN;
                        end
                    end
                    OP_CLEAR: begin
                        n_used   = '0;
                        n_lowest = '0;
                        n_state  = S_IDLE;
                    end
                    OP_DUMP: begin
                        n_pend.status = STS_ENTRY;
                        if (r_used != '0) begin
                            n_state = S_DUMP;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_MIN: begin
                // the running minimum ripples through every cell; the last cell ends with the true minimum
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(SLOTS)) begin
                    n_lowest = w_min_out[SLOTS-1];
                    n_state  = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = r_pend;
                    n_state     = S_IDLE;
                end
            end
            S_DUMP: begin
                // full rotation of the row so slot order is back in place at the end
                if (!w_emit || w_out_free) begin
                    w_shift = 1'b1;
                    n_cnt   = r_cnt + 1'b1;
                    if (w_emit) begin
                        n_out_valid         = 1'b1;
                        n_out.status        = STS_ENTRY;
                        n_out.slot          = 4'(r_cnt);
                        n_out.entry_valid   = 1'b1;
                        n_out.entry_key     = w_entry[0].key;
                        n_out.entry_latency = w_entry[0].latency;
                        n_out.entry_time    = w_entry[0].time_s;
                        n_out.last          = (CNT_W'(r_cnt + 1'b1) == w_dump_n);
                    end
                    if (r_cnt == CNT_W'(SLOTS - 1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_threshold <= THRESHOLD_RESET;
            r_used      <= '0;
            r_lowest    <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_lowest    <= n_lowest;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_threshold <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req <= i_in;
        end
        r_pend <= n_pend;
        r_out  <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

`default_nettype wire

// ===== tb/sv/tksrt_tb_pkg.sv =====
// Scoreboard for the slow-request table test: a predictor of the table and
// the queue of result beats it expects. Depends on tksrt_pkg.
package tksrt_tb_pkg;

    import tksrt_pkg::*;

    class slow_table_board;

        logic [63:0] keys [SLOTS];
        logic [31:0] lats [SLOTS];
        logic [39:0] stamps [SLOTS];
        int unsigned used;
        logic [31:0] lowest;
        logic [31:0] threshold;

        t_rsp        expected_beats [$];
        int unsigned mismatches;

        function new();
            for (int i = 0; i < SLOTS; i++) begin
                keys[i]   = '0;
                lats[i]   = '0;
                stamps[i] = '0;
            end
            used       = 0;
            lowest     = '0;
            threshold  = THRESHOLD_RESET;
            mismatches = 0;
        endfunction

        function void refresh_lowest();
            logic [31:0] m;
            m = 32'hFFFF_FFFF;
            for (int i = 0; i < used; i++) begin
                if (lats[i] < m) begin
                    m = lats[i];
                end
            end
            lowest = m;
        endfunction

        function void predict_add(t_req r);
            t_rsp beat;
            int   hit;
            int   pick;
            beat      = '0;
            beat.last = 1'b1;
            hit       = -1;
            if (r.latency < threshold) begin
                beat.status = STS_BELOW;
            end else if (used >= SLOTS && r.latency <= lowest) begin
                beat.status = STS_NOT_SLOW;
            end else begin
                for (int i = 0; i < used; i++) begin
                    if (hit < 0 && keys[i] == r.key_hash) begin
                        hit = i;
                    end
                end
                if (hit >= 0) begin
                    beat.slot = hit[3:0];
                    if (r.latency <= lats[hit]) begin
                        beat.status = STS_NOT_SLOWER;
                    end else begin
                        lats[hit]   = r.latency;
                        stamps[hit] = r.timestamp;
                        refresh_lowest();
                        beat.status = STS_UPDATED;
                    end
                end else begin
                    if (used < SLOTS) begin
                        pick = used;
                        used++;
                        beat.status = STS_INSERTED;
                    end else begin
                        // full: overwrite the first entry sitting at the minimum
                        pick = -1;
                        for (int i = 0; i < SLOTS; i++) begin
                            if (pick < 0 && lats[i] == lowest) begin
                                pick = i;
                            end
                        end
                        if (pick < 0) begin
                            pick = 0;
                        end
                        beat.status = STS_REPLACED;
                    end
                    keys[pick]   = r.key_hash;
                    lats[pick]   = r.latency;
                    stamps[pick] = r.timestamp;
                    refresh_lowest();
                    beat.slot = pick[3:0];
                end
            end
            expected_beats.push_back(beat);
        endfunction

        function void predict_dump();
            t_rsp beat;
            int   n;
            n = (used < DUMP_N) ? used : DUMP_N;
            if (n == 0) begin
                beat        = '0;
                beat.status = STS_ENTRY;
                beat.last   = 1'b1;
                expected_beats.push_back(beat);
            end
            for (int i = 0; i < n; i++) begin
                beat               = '0;
                beat.status        = STS_ENTRY;
                beat.slot          = i[3:0];
                beat.entry_valid   = 1'b1;
                beat.entry_key     = keys[i];
                beat.entry_latency = lats[i];
                beat.entry_time    = stamps[i];
                beat.last          = (i + 1 == n);
                expected_beats.push_back(beat);
            end
        endfunction

        function void log_request(t_req r);
            case (r.operation)
                OP_ADD: begin
                    predict_add(r);
                end
                OP_CLEAR: begin
                    used   = 0;
                    lowest = '0;
                end
                OP_DUMP: begin
                    predict_dump();
                end
                default: begin
                end
            endcase
        endfunction

        function void check_field(string name, logic [63:0] want, logic [63:0] got);
            if (got !== want) begin
                $error("%s: expected %0h, got %0h", name, want, got);
                mismatches++;
            end
        endfunction

        function void compare_beat(t_rsp got);
            t_rsp want;
            if (expected_beats.size() == 0) begin
                $error("result beat with nothing expected: %0h", got);
                mismatches++;
            end else begin
                want = expected_beats.pop_front();
                check_field("status", want.status, got.status);
                check_field("slot", want.slot, got.slot);
                check_field("entry_valid", want.entry_valid, got.entry_valid);
                check_field("entry_key", want.entry_key, got.entry_key);
                check_field("entry_latency", want.entry_latency, got.entry_latency);
                check_field("entry_time", want.entry_time, got.entry_time);
                check_field("last", want.last, got.last);
            end
        endfunction

    endclass

endpackage

// ===== tb/sv/top_k_slowest_request_table_test.sv =====
// Top of the slow-request table test: clock, reset, request driver, result
// stall generator and monitor. Depends on tksrt_pkg and tksrt_tb_pkg.
module top_k_slowest_request_table_test;

    timeunit 1ns;
    timeprecision 1ps;

    import tksrt_pkg::*;
    import tksrt_tb_pkg::*;

    localparam int LIMIT  = 1_000_000;
    localparam int SETTLE = 2 * SLOTS + 8;
    localparam int POOL_N = 24;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic [31:0] i_cfg_wdata = '0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_stall;
    t_req        i_in        = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_rsp        o_out;

    slow_table_board board;
    logic [63:0]     key_pool [POOL_N];
    bit              quiet = 1'b0;
    int unsigned     cycles = 0;

    top_k_slowest_request_table dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("top_k_slowest_request_table_test failed");
            $finish;
        end
    end

    // result side: values read here are the ones the block saw at this edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            board.compare_beat(o_out);
        end
    end

    initial begin
        int free_n;
        forever begin
            if (quiet) begin
                i_out_stall <= 1'b0;
                @(posedge i_clk);
            end else begin
                free_n = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 90)
                                                    : $urandom_range(1, 20);
                i_out_stall <= 1'b0;
                repeat (free_n) @(posedge i_clk);
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
            end
        end
    end

    function automatic t_req make_add(logic [63:0] key, logic [31:0] lat, logic [39:0] ts);
        t_req r;
        r.operation = OP_ADD;
        r.key_hash  = key;
        r.latency   = lat;
        r.timestamp = ts;
        return r;
    endfunction

    function automatic logic [31:0] sat_add(logic [31:0] a, logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic logic [63:0] pick_key();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 80) begin
            return key_pool[$urandom_range(0, POOL_N - 1)];
        end else if (roll < 85) begin
            return '0;
        end else if (roll < 90) begin
            return '1;
        end
        return {$urandom, $urandom};
    endfunction

    function automatic logic [39:0] pick_stamp();
        int          roll;
        logic [31:0] hi;
        roll = $urandom_range(0, 19);
        hi   = $urandom_range(0, 255);
        if (roll == 0) begin
            return '0;
        end else if (roll == 1) begin
            return '1;
        end
        return {hi[7:0], $urandom};
    endfunction

    // latencies aimed at the threshold and the stored minimum boundaries
    function automatic logic [31:0] pick_latency();
        logic [31:0] thr;
        thr = board.threshold;
        case ($urandom_range(0, 9))
            0: return (thr == 0) ? 32'd0 : $urandom_range(0, thr - 1);
            1: return thr;
            2: return board.lowest;
            3: return sat_add(board.lowest, 32'd1);
            4: return 32'hFFFF_FFFF;
            5: return 32'd0;
            6: return sat_add(thr, $urandom_range(0, 1000));
            7: return (thr == 0) ? $urandom : $urandom_range(32'hFFFF_FFFF, thr);
            default: return $urandom;
        endcase
    endfunction

    function automatic t_req random_request();
        t_req r;
        int   roll;
        r    = make_add(pick_key(), pick_latency(), pick_stamp());
        roll = $urandom_range(0, 99);
        if (roll >= 97) begin
            r.operation = 2'd3;
        end else if (roll >= 94) begin
            r.operation = OP_CLEAR;
        end else if (roll >= 80) begin
            r.operation = OP_DUMP;
        end
        return r;
    endfunction

    // entered and left on a rising edge; valid stays high after the beat
    task automatic send_request(t_req r);
        int gap;
        gap = (!quiet && $urandom_range(0, 2) == 0) ? $urandom_range(1, 14) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in       <= r;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0) @(posedge i_clk);
        board.log_request(r);
    endtask

    // clear and ignored codes give no beat, hence the settle time
    task automatic drain_and_settle();
        i_in_valid <= 1'b0;
        while (board.expected_beats.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_threshold(logic [31:0] v);
        drain_and_settle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we        <= 1'b0;
        board.threshold  = v;
    endtask

    task automatic run_random(int n);
        t_req r;
        int   done;
        done = 0;
        while (done < n) begin
            r = random_request();
            send_request(r);
            if (r.operation != 2'd3) begin
                done++;
            end
        end
    endtask

    initial begin
        t_req        r;
        logic [63:0] k;
        logic [31:0] thr_rand;

        board = new();
        for (int i = 0; i < POOL_N; i++) begin
            key_pool[i] = {$urandom, $urandom};
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty dump, threshold edge, key dedup, ignored code, clear
        r = '0;
        r.operation = OP_DUMP;
        send_request(r);
        k = key_pool[0];
        send_request(make_add(k, THRESHOLD_RESET - 1, pick_stamp()));
        send_request(make_add(k, THRESHOLD_RESET, pick_stamp()));
        send_request(make_add(k, THRESHOLD_RESET, pick_stamp()));
        send_request(make_add(k, 32'd20000, pick_stamp()));
        r.operation = 2'd3;
        send_request(r);
        r.operation = OP_CLEAR;
        send_request(r);

        // fill the table; slots 0 and 8 share the minimum
        for (int i = 0; i < SLOTS; i++) begin
            k = (i == 0) ? 64'd0 : (i == SLOTS - 1) ? '1 : key_pool[i];
            send_request(make_add(k, 32'd20000 + (i % 8) * 1000,
                                  (i == 0) ? 40'd0 : (i == 1) ? '1 : pick_stamp()));
        end
        send_request(make_add(key_pool[20], 32'd20000, pick_stamp()));
        send_request(make_add(key_pool[21], 32'd30000, pick_stamp()));
        r.operation = OP_DUMP;
        send_request(r);

        run_random(80);
        write_threshold(32'd0);
        run_random(75);
        write_threshold(32'hFFFF_FFFF);
        run_random(40);
        thr_rand = $urandom;
        write_threshold(thr_rand);
        run_random(70);
        write_threshold(32'd1);
        run_random(70);
        thr_rand = $urandom_range(10, 100000);
        write_threshold(thr_rand);
        run_random(70);
        write_threshold(THRESHOLD_RESET);
        quiet = 1'b1;
        run_random(65);

        drain_and_settle();
        if (board.mismatches == 0 && board.expected_beats.size() == 0) begin
            $display("top_k_slowest_request_table_test passed");
        end else begin
            $display("top_k_slowest_request_table_test failed");
        end
        $finish;
    end

endmodule
